// ===== sv/tlv_record_search_assert.svh =====
// ----------------------------------------------------------------------------
// tlv record search assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TLV_RECORD_SEARCH_ASSERT_SVH
`define TLV_RECORD_SEARCH_ASSERT_SVH

// same-cycle implication
`define TLVRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLVRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tlvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlv record search package
// register indexes, phase and status codes, and shared types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlvrs_pkg;

  localparam int unsigned HEADER_BYTES = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCHED_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE  = 3'd4;

  localparam logic [7:0] ID_COUNT_RESET = 8'd22;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_VALUE  = 3'd5;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  typedef struct packed {
    logic [7:0]  searched_type;
    logic [7:0]  id_count;
    logic [15:0] max_record_length;
    logic [15:0] out_capacity;
    logic [15:0] payload_size;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [1:0]  search_status;
    logic [15:0] record_offset;
    logic [15:0] record_length;
    logic        last_result;
  } res_t;

endpackage

// ===== sv/tlvrs_parser.sv =====
// ----------------------------------------------------------------------------
// tlv record search parser
// per-byte phase tracking, record checks and result formation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlvrs_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  tlvrs_pkg::cfg_t   cfg,
  output tlvrs_pkg::res_t   res
);
  import tlvrs_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_eff;
  logic [15:0]        start_r, start_nxt, start_eff;
  logic [7:0]         type_r, type_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        left_r, left_nxt;
  logic [15:0]        len_full;
  logic [16:0]        next_start;
  res_t               res_c;

  always_comb begin
    phase_eff  = first_byte ? PH_TYPE : phase_r;
    start_eff  = first_byte ? 16'd0 : start_r;
    len_full   = {data_byte, len_r[7:0]};
    next_start = {1'b0, start_eff} + 17'(HEADER_BYTES) + {1'b0, len_full};

    phase_nxt = phase_r;
    start_nxt = start_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    res_c     = '0;

    if (step) begin
      start_nxt = start_eff;
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_DONE: begin
        end
        PH_TYPE: begin
          if (start_eff >= cfg.payload_size) begin
            phase_nxt           = PH_DONE;
            res_c.emit          = 1'b1;
            res_c.search_status = ST_NOT_FOUND;
            res_c.last_result   = 1'b1;
          end else begin
            type_nxt  = data_byte;
            phase_nxt = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          len_nxt   = {8'd0, data_byte};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt = len_full;
          if (type_r == cfg.searched_type) begin
            phase_nxt           = PH_DONE;
            res_c.record_offset = start_eff;
            res_c.record_length = len_full;
            res_c.last_result   = 1'b1;
            priority if (type_r >= cfg.id_count || len_full > cfg.max_record_length) begin
              res_c.emit          = 1'b1;
              res_c.search_status = ST_NOT_FOUND;
            end else if (cfg.out_capacity < len_full) begin
              res_c.emit          = 1'b1;
              res_c.search_status = ST_TOO_SMALL;
            end else if (len_full == 16'd0) begin
              res_c.emit          = 1'b1;
              res_c.search_status = ST_FOUND;
            end else begin
              left_nxt  = len_full;
              phase_nxt = PH_VALUE;
            end
          end else if (next_start >= {1'b0, cfg.payload_size}) begin
            phase_nxt           = PH_DONE;
            res_c.emit          = 1'b1;
            res_c.search_status = ST_NOT_FOUND;
            res_c.last_result   = 1'b1;
          end else begin
            start_nxt = next_start[15:0];
            left_nxt  = len_full;
            phase_nxt = (len_full == 16'd0) ? PH_TYPE : PH_SKIP;
          end
        end
        PH_SKIP: begin
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_VALUE: begin
          left_nxt            = left_r - 16'd1;
          res_c.emit          = 1'b1;
          res_c.value_byte    = data_byte;
          res_c.value_valid   = 1'b1;
          res_c.search_status = ST_FOUND;
          res_c.record_offset = start_eff;
          res_c.record_length = len_r;
          res_c.last_result   = (left_r == 16'd1);
          if (left_r == 16'd1) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    type_r  <= type_nxt;
    len_r   <= len_nxt;
    left_r  <= left_nxt;
  end

`include "tlv_record_search_assert.svh"

  `TLVRS_ASSERT_NOW(a_skip_count, phase_r == PH_SKIP, left_r != 16'd0, "skip with no bytes left")
  `TLVRS_ASSERT_NOW(a_value_count, phase_r == PH_VALUE, left_r != 16'd0, "value with no bytes left")
  `TLVRS_ASSERT_NEXT(a_idle_hold, step && !first_byte && phase_r == PH_DONE, phase_r == PH_DONE, "idle byte left done phase")
  `TLVRS_ASSERT_NOW(a_final_done, step && res.emit && res.last_result, phase_nxt == PH_DONE, "final result without ending search")

endmodule

// ===== sv/tlv_record_search.sv =====
// ----------------------------------------------------------------------------
// tlv record search top level
// configuration registers, input register, parser and result register
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle while in_stall is low; a result for a byte
// passes from the input register through the combinational parser into the
// result register. Stall on the result side holds the input register, and the
// input stalls only while both registers are full.
`timescale 1ns / 1ps

module tlv_record_search (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlvrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_payload_byte,
  input  logic                           in_first_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_value_byte,
  output logic                           out_value_valid,
  output logic [1:0]                     out_search_status,
  output logic [15:0]                    out_record_offset,
  output logic [15:0]                    out_record_length,
  output logic                           out_last_result
);
  import tlvrs_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       out_free, s1_adv, in_take;
  res_t       res;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEARCHED_TYPE: cfg_nxt.searched_type     = cfg_wdata[7:0];
        CFG_ID_COUNT:      cfg_nxt.id_count          = cfg_wdata[7:0];
        CFG_MAX_LENGTH:    cfg_nxt.max_record_length = cfg_wdata;
        CFG_OUT_CAPACITY:  cfg_nxt.out_capacity      = cfg_wdata;
        CFG_PAYLOAD_SIZE:  cfg_nxt.payload_size      = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_adv && res.emit;
    end
  end

  tlvrs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.searched_type     <= 8'd0;
      cfg_r.id_count          <= ID_COUNT_RESET;
      cfg_r.max_record_length <= 16'd0;
      cfg_r.out_capacity      <= 16'd0;
      cfg_r.payload_size      <= 16'd0;
      s1_valid_r              <= 1'b0;
      out_valid_r             <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_payload_byte;
      s1_first_r <= in_first_byte;
    end
    if (out_free && s1_adv && res.emit) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_byte    = out_r.value_byte;
  assign out_value_valid   = out_r.value_valid;
  assign out_search_status = out_r.search_status;
  assign out_record_offset = out_r.record_offset;
  assign out_record_length = out_r.record_length;
  assign out_last_result   = out_r.last_result;

`include "tlv_record_search_assert.svh"

  `TLVRS_ASSERT_NOW(a_data_found, out_valid && out_value_valid, out_search_status == ST_FOUND, "value byte with error status")
  `TLVRS_ASSERT_NOW(a_error_last, out_valid && out_search_status != ST_FOUND, out_last_result, "error request not final")
  `TLVRS_ASSERT_NEXT(a_held_input, s1_valid_r && !out_free, s1_valid_r && $stable(s1_byte_r), "input register lost a request")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// tlv record search testbench
// streams record payloads into the block, predicts every search result from
// a local copy of the parser and registers, and compares each result field by
// field; a short directed part covers the corner cases, then random searches
// with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tlvrs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 1500;
  localparam int MAX_REPORTS  = 100;

  typedef struct {
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [1:0]  status;
    logic [15:0] offset;
    logic [15:0] length;
    logic        last;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_payload_byte;
  logic in_first_byte;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_value_byte;
  logic out_value_valid;
  logic [1:0] out_search_status;
  logic [15:0] out_record_offset;
  logic [15:0] out_record_length;
  logic out_last_result;

  // local copy of the registers and the parser
  cfg_t regs;
  logic [PHASE_W-1:0] parse_phase;
  logic [15:0] rec_start;
  logic [15:0] rec_len;
  logic [15:0] value_left;
  logic [7:0] rec_type;

  search_result_t awaited_results[$];
  int mismatches = 0;
  int live_bytes = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  tlv_record_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_byte    (out_value_byte),
    .out_value_valid   (out_value_valid),
    .out_search_status (out_search_status),
    .out_record_offset (out_record_offset),
    .out_record_length (out_record_length),
    .out_last_result   (out_last_result)
  );

  function automatic void expect_result(input logic [7:0] vb, input logic vv,
                                        input logic [1:0] st, input logic [15:0] off,
                                        input logic [15:0] len, input logic last);
    search_result_t r;
    r.value_byte = vb;
    r.value_valid = vv;
    r.status = st;
    r.offset = off;
    r.length = len;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  task automatic parse_payload_byte(input logic [7:0] b, input logic first);
    logic [31:0] next_start;
    live_bytes++;
    if (first) begin
      parse_phase = PH_TYPE;
      rec_start = '0;
    end
    if (parse_phase == PH_DONE) return;
    case (parse_phase)
      PH_TYPE: begin
        if (rec_start >= regs.payload_size) begin
          parse_phase = PH_DONE;
          expect_result(8'h00, 1'b0, ST_NOT_FOUND, 16'h0000, 16'h0000, 1'b1);
        end else begin
          rec_type = b;
          parse_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        rec_len = {8'h00, b};
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        rec_len[15:8] = b;
        if (rec_type == regs.searched_type) begin
          parse_phase = PH_DONE;
          if (rec_type >= regs.id_count || rec_len > regs.max_record_length) begin
            expect_result(8'h00, 1'b0, ST_NOT_FOUND, rec_start, rec_len, 1'b1);
          end else if (regs.out_capacity < rec_len) begin
            expect_result(8'h00, 1'b0, ST_TOO_SMALL, rec_start, rec_len, 1'b1);
          end else if (rec_len == 16'h0000) begin
            expect_result(8'h00, 1'b0, ST_FOUND, rec_start, 16'h0000, 1'b1);
          end else begin
            value_left = rec_len;
            parse_phase = PH_VALUE;
          end
        end else begin
          next_start = 32'(rec_start) + 32'(HEADER_BYTES) + 32'(rec_len);
          if (next_start >= 32'(regs.payload_size)) begin
            parse_phase = PH_DONE;
            expect_result(8'h00, 1'b0, ST_NOT_FOUND, 16'h0000, 16'h0000, 1'b1);
          end else begin
            rec_start = next_start[15:0];
            if (rec_len == 16'h0000) begin
              parse_phase = PH_TYPE;
            end else begin
              value_left = rec_len;
              parse_phase = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        value_left = value_left - 16'h0001;
        if (value_left == 16'h0000) parse_phase = PH_TYPE;
      end
      PH_VALUE: begin
        value_left = value_left - 16'h0001;
        expect_result(b, 1'b1, ST_FOUND, rec_start, rec_len, value_left == 16'h0000);
        if (value_left == 16'h0000) parse_phase = PH_DONE;
      end
      default: parse_phase = PH_DONE;
    endcase
  endtask

  // called at a falling edge, returns at a falling edge with the request still offered
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_payload_byte = b;
    in_first_byte = first;
    do @(posedge clk); while (in_stall);
    parse_payload_byte(b, first);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SEARCHED_TYPE: regs.searched_type = data[7:0];
      CFG_ID_COUNT:      regs.id_count = data[7:0];
      CFG_MAX_LENGTH:    regs.max_record_length = data;
      CFG_OUT_CAPACITY:  regs.out_capacity = data;
      CFG_PAYLOAD_SIZE:  regs.payload_size = data;
      default: ;
    endcase
  endtask

  // drop the request and let the block drain
  task automatic settle();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      stall_left = idle_on ? $urandom_range(0, 12) : 0;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result expected none actual status %0d byte %0h",
                   $time, out_search_status, out_value_byte);
      end else begin
        want = awaited_results.pop_front();
        check_field("value_byte", 16'(want.value_byte), 16'(out_value_byte));
        check_field("value_valid", 16'(want.value_valid), 16'(out_value_valid));
        check_field("search_status", 16'(want.status), 16'(out_search_status));
        check_field("record_offset", want.offset, out_record_offset);
        check_field("record_length", want.length, out_record_length);
        check_field("last_result", 16'(want.last), 16'(out_last_result));
      end
    end
  end

  // receiver: random stall after each result, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: timeout, no request moved for %0d cycles", $time, quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_idle_and_empty();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
  endtask

  task automatic test_found_extremes();
    write_reg(CFG_SEARCHED_TYPE, 16'h00FE);
    write_reg(CFG_ID_COUNT, 16'h00FF);
    write_reg(CFG_MAX_LENGTH, 16'hFFFF);
    write_reg(CFG_OUT_CAPACITY, 16'hFFFF);
    write_reg(CFG_PAYLOAD_SIZE, 16'hFFFF);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
  endtask

  task automatic test_failed_checks();
    // type not below id count
    write_reg(CFG_SEARCHED_TYPE, 16'h00FF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    // length above maximum
    write_reg(CFG_SEARCHED_TYPE, 16'h0007);
    write_reg(CFG_ID_COUNT, 16'h0008);
    write_reg(CFG_MAX_LENGTH, 16'h0004);
    send_byte(8'h07, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    // buffer too small
    write_reg(CFG_MAX_LENGTH, 16'h0005);
    write_reg(CFG_OUT_CAPACITY, 16'h0004);
    send_byte(8'h07, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
  endtask

  task automatic test_restart_and_zero_length();
    write_reg(CFG_OUT_CAPACITY, 16'h0005);
    send_byte(8'h07, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h07, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
  endtask

  task automatic test_payload_end();
    write_reg(CFG_PAYLOAD_SIZE, 16'h0003);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    write_reg(CFG_PAYLOAD_SIZE, 16'h0006);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_PAYLOAD_SIZE, 16'hFFFF);
    write_reg(CFG_MAX_LENGTH, 16'hFFFF);
    write_reg(CFG_OUT_CAPACITY, 16'hFFFF);
    idle_on = 1'b0;
    hold_request = 1'b1;
    send_byte(8'h07, 1'b1);
    send_byte(8'h28, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (40) send_byte(8'($urandom), 1'b0);
    settle();
    idle_on = 1'b1;
  endtask

  function automatic logic [15:0] pick_limit(input logic [15:0] len);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return (len == 16'h0000) ? 16'h0000 : len - 16'h0001;
      2: return len;
      3: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_record_length();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) return 16'($urandom_range(0, 16'hFFFF));
    if (r < 4) return 16'($urandom_range(16, 70));
    return 16'($urandom_range(0, 6));
  endfunction

  task automatic random_search();
    logic [7:0] stream[$];
    logic [7:0] want_type;
    logic [7:0] rtype;
    logic [7:0] idc;
    logic [7:0] junk;
    logic [15:0] rlen;
    logic [15:0] hit_len;
    logic [15:0] psize;
    int unsigned total;
    int nrec;
    int hit;
    int cut;
    bit reconf;
    reconf = ($urandom_range(0, 1) == 0);
    idle_on = ($urandom_range(0, 3) != 0);
    hit_len = 16'h0000;
    total = 0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if (reconf)
      want_type = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 254));
    else
      want_type = regs.searched_type;
    nrec = $urandom_range(1, 4);
    hit = $urandom_range(0, nrec);
    for (int i = 0; i < nrec; i++) begin
      rtype = 8'($urandom);
      if (i == hit) rtype = want_type;
      else if (rtype == want_type) rtype = rtype ^ 8'h01;
      rlen = pick_record_length();
      if (i == hit) hit_len = rlen;
      total += 3 + rlen;
      stream.push_back(rtype);
      stream.push_back(rlen[7:0]);
      stream.push_back(rlen[15:8]);
      repeat ((rlen > 16'd40) ? 40 : int'(rlen)) stream.push_back(8'($urandom));
    end
    if (reconf) begin
      case ($urandom_range(0, 5))
        0: idc = 8'd1;
        1: idc = (want_type == 8'h00) ? 8'd1 : want_type;
        2: idc = (want_type == 8'hFF) ? 8'hFF : want_type + 8'd1;
        3: idc = 8'($urandom_range(1, 255));
        default: idc = 8'hFF;
      endcase
      case ($urandom_range(0, 5))
        0: psize = 16'h0000;
        1: psize = 16'($urandom_range(0, (total > 65535) ? 65535 : total));
        2: psize = 16'hFFFF;
        default: psize = (total > 65535) ? 16'hFFFF : 16'(total);
      endcase
      settle();
      junk = 8'($urandom);
      write_reg(CFG_SEARCHED_TYPE, {junk, want_type});
      junk = 8'($urandom);
      write_reg(CFG_ID_COUNT, {junk, idc});
      write_reg(CFG_MAX_LENGTH, pick_limit(hit_len));
      write_reg(CFG_OUT_CAPACITY, pick_limit(hit_len));
      write_reg(CFG_PAYLOAD_SIZE, psize);
    end
    cut = stream.size();
    if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, stream.size());
    for (int k = 0; k < cut; k++) send_byte(stream[k], k == 0);
  endtask

  task automatic test_random_searches();
    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) random_search();
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_payload_byte = 8'h00;
    in_first_byte = 1'b0;
    regs.searched_type = 8'h00;
    regs.id_count = ID_COUNT_RESET;
    regs.max_record_length = 16'h0000;
    regs.out_capacity = 16'h0000;
    regs.payload_size = 16'h0000;
    parse_phase = PH_DONE;
    rec_start = '0;
    rec_len = '0;
    value_left = '0;
    rec_type = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_idle_and_empty();
    test_found_extremes();
    test_failed_checks();
    test_restart_and_zero_length();
    test_payload_end();
    test_backpressure();
    test_random_searches();

    repeat (10) @(negedge clk);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results expected but never seen", $time, awaited_results.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tlvrs_pkg.sv
sv/tlvrs_parser.sv
sv/tlv_record_search.sv
sim/testbench.sv
